@@ rtl/apm_pkg.sv @@
`timescale 1ns / 1ps

package apm_pkg;

    // Parameter defaults
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_TICK_MS  = 100;

    // Channel field is 3 bits wide, so never more than 8 channels
    localparam int CH_LIMIT = 8;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int CH_W     = 3;
    localparam int LEVEL_W  = 17;
    localparam int EMS_W    = 10;
    localparam int CCNT_W   = 4;
    localparam int RATE_W   = 18;
    localparam int MS_W     = 14;
    localparam int MODE_W   = 2;
    localparam int AGE_W    = 14;

    // APB side
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int RIDX_W   = 3;

    // Arithmetic constants
    localparam int  AGE_MAX    = 16383;
    localparam int  RATE_MAX   = 262143;
    localparam int  ROUND_HALF = 500;
    localparam int  DIVISOR    = 1000;
    localparam int  DIV_LOG2   = 10;

    // Register reset values
    localparam logic        [CCNT_W-1:0]  RST_CHANNEL_COUNT = 4'd1;
    localparam logic signed [LEVEL_W-1:0] RST_MIN_LEVEL     = -17'sd15360;
    localparam logic signed [LEVEL_W-1:0] RST_MAX_LEVEL     = 17'sd0;
    localparam logic        [RATE_W-1:0]  RST_DECAY_RATE    = 18'd5120;
    localparam logic        [RATE_W-1:0]  RST_PEAK_DECAY    = 18'd5120;
    localparam logic        [MS_W-1:0]    RST_PEAK_HOLD_MS  = 14'd1000;
    localparam logic        [MS_W-1:0]    RST_TIMEOUT_MS    = 14'd0;
    localparam logic        [MODE_W-1:0]  RST_MODE_FLAGS    = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_LEVEL       = 2'd0,
        KIND_TICK        = 2'd1,
        KIND_RESET_PEAKS = 2'd2,
        KIND_CLEAR       = 2'd3
    } t_kind;

    typedef enum logic [RIDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_MIN_LEVEL     = 3'd1,
        REG_MAX_LEVEL     = 3'd2,
        REG_DECAY_RATE    = 3'd3,
        REG_PEAK_DECAY    = 3'd4,
        REG_PEAK_HOLD_MS  = 3'd5,
        REG_TIMEOUT_MS    = 3'd6,
        REG_MODE_FLAGS    = 3'd7
    } t_reg_idx;

endpackage

@@ rtl/audio_peak_meter_ballistics.sv @@
`timescale 1ns / 1ps

// Level sample: accepted when idle, result registered in S_SAMPLE once the output register is free;
// no new input is taken until the sample is done. Tick with animation: DMUL, DDIV, PMUL, PDIV
// on the shared multiplier (two decay steps, each a rate*ms product then a reciprocal multiply
// for /1000), then one result per active channel, one per cycle while the output is not stalled.
// Reset peaks, clear, and ticks without animation go from idle straight to the sweep.
// Synchronous active-low reset restores register defaults and floors all channel state.
module audio_peak_meter_ballistics #(
    parameter int MAX_CHANNELS = apm_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_TICK_MS  = apm_pkg::DEF_MAX_TICK_MS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [apm_pkg::ADDR_W-1:0]         paddr,
    input  logic [apm_pkg::DATA_W-1:0]         pwdata,
    output logic [apm_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [apm_pkg::KIND_W-1:0]         i_kind,
    input  logic [apm_pkg::CH_W-1:0]           i_channel,
    input  logic signed [apm_pkg::LEVEL_W-1:0] i_level_in,
    input  logic [apm_pkg::EMS_W-1:0]          i_elapsed_ms,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [apm_pkg::CH_W-1:0]           o_out_channel,
    output logic signed [apm_pkg::LEVEL_W-1:0] o_displayed_level,
    output logic signed [apm_pkg::LEVEL_W-1:0] o_peak_level,
    output logic                               o_peak_changed,
    output logic                               o_timed_out,
    output logic                               o_last
);
    import apm_pkg::*;

    // Storage depth: the channel field cannot address more than CH_LIMIT entries
    localparam int NCH = (MAX_CHANNELS > CH_LIMIT) ? CH_LIMIT : MAX_CHANNELS;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;     // channel index
    localparam int NW  = $clog2(NCH + 1);                 // active count / sweep counter
    localparam int MSW = $clog2(MAX_TICK_MS + 1);         // capped tick ms

    // Decay step = (rate*ms + 500) / 1000, done as x * ceil(2^SH/1000) >> SH,
    // exact for every x below 2^XW.
    localparam longint XMAX = longint'(RATE_MAX) * longint'(MAX_TICK_MS)
                              + longint'(ROUND_HALF);
    localparam int     XW   = $clog2(XMAX + 1);
    localparam int     SH   = XW + DIV_LOG2;
    localparam longint MULT = ((longint'(1) << SH) + longint'(DIVISOR) - 1)
                              / longint'(DIVISOR);
    localparam int     MW   = $clog2(MULT + 1);
    localparam int     PW   = XW + MW;

    // Signed headroom for level minus step
    localparam int EXT_W = LEVEL_W + 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMPLE,
        S_DMUL,
        S_DDIV,
        S_PMUL,
        S_PDIV,
        S_SWEEP
    } t_state;

    // ---------------- configuration registers ----------------
    logic        [CCNT_W-1:0]  r_channel_count;
    logic signed [LEVEL_W-1:0] r_min_level;
    logic signed [LEVEL_W-1:0] r_max_level;
    logic        [RATE_W-1:0]  r_decay_rate;
    logic        [RATE_W-1:0]  r_peak_decay;
    logic        [MS_W-1:0]    r_peak_hold_ms;
    logic        [MS_W-1:0]    r_timeout_ms;
    logic        [MODE_W-1:0]  r_mode_flags;

    // ---------------- per-channel state ----------------
    logic signed [LEVEL_W-1:0] r_target [NCH];
    logic signed [LEVEL_W-1:0] r_shown  [NCH];
    logic signed [LEVEL_W-1:0] r_peak   [NCH];
    logic        [MS_W-1:0]    r_hold   [NCH];
    logic        [AGE_W-1:0]   r_age;
    logic                      r_age_valid;

    // ---------------- sequencer and datapath registers ----------------
    t_state                    r_state;
    logic [CH_W-1:0]           r_ch;        // channel of a pending sample
    logic signed [LEVEL_W-1:0] r_level;     // level of a pending sample
    logic [MSW-1:0]            r_ms;        // tick time, capped
    logic [NW-1:0]             r_idx;       // sweep position
    logic                      r_upd;       // sweep applies decay (else report only)
    logic                      r_tmo;       // timeout fired on this tick
    logic [NCH-1:0]            r_pchg;      // peak-changed flags for report-only sweeps
    logic [PW-1:0]             r_prod;      // shared multiplier result
    logic [RATE_W-1:0]         r_dstep;     // shown-level decay step of this tick

    // output register
    logic                      r_o_valid;
    logic [CH_W-1:0]           r_o_channel;
    logic signed [LEVEL_W-1:0] r_o_shown;
    logic signed [LEVEL_W-1:0] r_o_peak;
    logic                      r_o_pchg;
    logic                      r_o_tmo;
    logic                      r_o_last;

    // ---------------- combinational signals ----------------
    logic [CCNT_W-1:0]         w_cc_nz;
    logic [NW-1:0]             w_n;         // active channel count, 1..NCH
    logic                      w_in_acc;
    logic                      w_cfg_wr;
    logic                      w_slot;      // output register free this cycle
    logic                      w_o_load;    // output register takes a new result
    logic                      w_last;
    logic                      w_hold_on;
    logic                      w_anim_on;
    logic [CW-1:0]             w_ridx;      // read/write address of the arrays in the sample and sweep states
    logic [AGE_W:0]            w_age_sum;
    logic [XW-1:0]             w_mul_a;
    logic [MW-1:0]             w_mul_b;
    logic [PW-1:0]             w_prod;
    logic [PW-1:0]             w_quot;
    logic [RATE_W-1:0]         w_step;

    logic signed [LEVEL_W-1:0] w_old_shown;
    logic signed [LEVEL_W-1:0] w_old_peak;
    logic        [MS_W-1:0]    w_old_hold;
    logic signed [LEVEL_W-1:0] w_lv_hi;
    logic signed [LEVEL_W-1:0] w_bound;
    logic signed [LEVEL_W-1:0] w_tgt;
    logic signed [EXT_W-1:0]   w_shown_dec;
    logic signed [EXT_W-1:0]   w_peak_dec;
    logic signed [LEVEL_W-1:0] w_new_shown;
    logic signed [LEVEL_W-1:0] w_new_peak;
    logic        [MS_W-1:0]    w_new_hold;
    logic                      w_new_pchg;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_CHANNEL_COUNT: prdata = DATA_W'(r_channel_count);
            REG_MIN_LEVEL:     prdata = DATA_W'(r_min_level);
            REG_MAX_LEVEL:     prdata = DATA_W'(r_max_level);
            REG_DECAY_RATE:    prdata = DATA_W'(r_decay_rate);
            REG_PEAK_DECAY:    prdata = DATA_W'(r_peak_decay);
            REG_PEAK_HOLD_MS:  prdata = DATA_W'(r_peak_hold_ms);
            REG_TIMEOUT_MS:    prdata = DATA_W'(r_timeout_ms);
            REG_MODE_FLAGS:    prdata = DATA_W'(r_mode_flags);
            default:           prdata = '0;
        endcase
    end

    // ---------------- control decode ----------------
    // Active count: zero reads as one, clamped to the storage depth
    assign w_cc_nz   = (r_channel_count == '0) ? CCNT_W'(1) : r_channel_count;
    assign w_n       = (w_cc_nz > CCNT_W'(NCH)) ? NW'(NCH) : NW'(w_cc_nz);
    assign w_hold_on = r_mode_flags[0];
    assign w_anim_on = r_mode_flags[1];

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_slot   = !r_o_valid || i_ready;
    assign w_o_load = w_slot && ((r_state == S_SAMPLE) || (r_state == S_SWEEP));
    assign w_last   = (NW'(r_idx + 1'b1) == w_n);
    assign w_ridx   = (r_state == S_SAMPLE) ? r_ch[CW-1:0] : r_idx[CW-1:0];

    assign w_age_sum = (AGE_W + 1)'(r_age) + (AGE_W + 1)'(i_elapsed_ms);

    // ---------------- shared multiplier ----------------
    // rate*ms on the MUL steps, (product + 1/2) * reciprocal on the DIV steps
    always_comb begin
        priority case (r_state)
            S_DMUL: begin
                w_mul_a = XW'(r_decay_rate);
                w_mul_b = MW'(r_ms);
            end
            S_PMUL: begin
                w_mul_a = XW'(r_peak_decay);
                w_mul_b = MW'(r_ms);
            end
            default: begin
                w_mul_a = r_prod[XW-1:0] + XW'(ROUND_HALF);
                w_mul_b = MW'(MULT);
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_quot = r_prod >> SH;
    assign w_step = w_quot[RATE_W-1:0];   // peak step while sweeping

    // ---------------- channel update ----------------
    assign w_old_shown = r_shown[w_ridx];
    assign w_old_peak  = r_peak[w_ridx];
    assign w_old_hold  = r_hold[w_ridx];

    // sample bound: floor wins when the bounds cross
    assign w_lv_hi = (r_level > r_max_level) ? r_max_level : r_level;
    assign w_bound = (w_lv_hi < r_min_level) ? r_min_level : w_lv_hi;

    assign w_tgt       = r_tmo ? r_min_level : r_target[w_ridx];
    assign w_shown_dec = EXT_W'(w_old_shown) - $signed(EXT_W'(r_dstep));
    assign w_peak_dec  = EXT_W'(w_old_peak) - $signed(EXT_W'(w_step));

    always_comb begin
        w_new_shown = w_old_shown;
        w_new_peak  = w_old_peak;
        w_new_hold  = w_old_hold;
        if (r_state == S_SAMPLE) begin
            if (!w_anim_on || (w_bound >= w_old_shown)) begin
                w_new_shown = w_bound;
            end
            if (w_bound >= w_old_peak) begin
                w_new_peak = w_bound;
                w_new_hold = r_peak_hold_ms;
            end
        end else if (r_upd) begin
            // linear fall toward the target, never below it
            if (w_tgt >= w_old_shown) begin
                w_new_shown = w_tgt;
            end else if (w_shown_dec > EXT_W'(w_tgt)) begin
                w_new_shown = w_shown_dec[LEVEL_W-1:0];
            end else begin
                w_new_shown = w_tgt;
            end
            if (!w_hold_on) begin
                w_new_peak = w_new_shown;
            end else if (w_new_shown > w_old_peak) begin
                w_new_peak = w_new_shown;
                w_new_hold = r_peak_hold_ms;
            end else if (w_old_hold != '0) begin
                w_new_hold = (w_old_hold > MS_W'(r_ms)) ? (w_old_hold - MS_W'(r_ms)) : '0;
            end else if (w_peak_dec > EXT_W'(w_new_shown)) begin
                w_new_peak = w_peak_dec[LEVEL_W-1:0];
            end else begin
                w_new_peak = w_new_shown;
            end
        end
        // report-only sweeps carry the flags worked out at accept
        w_new_pchg = (r_state == S_SAMPLE || r_upd) ? (w_new_peak != w_old_peak)
                                                     : r_pchg[w_ridx];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_min_level     <= RST_MIN_LEVEL;
            r_max_level     <= RST_MAX_LEVEL;
            r_decay_rate    <= RST_DECAY_RATE;
            r_peak_decay    <= RST_PEAK_DECAY;
            r_peak_hold_ms  <= RST_PEAK_HOLD_MS;
            r_timeout_ms    <= RST_TIMEOUT_MS;
            r_mode_flags    <= RST_MODE_FLAGS;
            for (int i = 0; i < NCH; i++) begin
                r_target[i] <= RST_MIN_LEVEL;
                r_shown[i]  <= RST_MIN_LEVEL;
                r_peak[i]   <= RST_MIN_LEVEL;
                r_hold[i]   <= '0;
            end
            r_age       <= '0;
            r_age_valid <= 1'b0;
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_level     <= '0;
            r_ms        <= '0;
            r_idx       <= '0;
            r_upd       <= 1'b0;
            r_tmo       <= 1'b0;
            r_pchg      <= '0;
            r_prod      <= '0;
            r_dstep     <= '0;
            r_o_valid   <= 1'b0;
            r_o_channel <= '0;
            r_o_shown   <= '0;
            r_o_peak    <= '0;
            r_o_pchg    <= 1'b0;
            r_o_tmo     <= 1'b0;
            r_o_last    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_CHANNEL_COUNT: r_channel_count <= pwdata[CCNT_W-1:0];
                    REG_MIN_LEVEL:     r_min_level     <= $signed(pwdata[LEVEL_W-1:0]);
                    REG_MAX_LEVEL:     r_max_level     <= $signed(pwdata[LEVEL_W-1:0]);
                    REG_DECAY_RATE:    r_decay_rate    <= pwdata[RATE_W-1:0];
                    REG_PEAK_DECAY:    r_peak_decay    <= pwdata[RATE_W-1:0];
                    REG_PEAK_HOLD_MS:  r_peak_hold_ms  <= pwdata[MS_W-1:0];
                    REG_TIMEOUT_MS:    r_timeout_ms    <= pwdata[MS_W-1:0];
                    REG_MODE_FLAGS:    r_mode_flags    <= pwdata[MODE_W-1:0];
                    default: ;
                endcase
            end

            if (r_o_valid && i_ready && !w_o_load) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ch    <= i_channel;
                        r_level <= i_level_in;
                        r_idx   <= '0;
                        r_tmo   <= 1'b0;
                        r_upd   <= 1'b0;
                        r_ms    <= ((EMS_W + 1)'(i_elapsed_ms) > (EMS_W + 1)'(MAX_TICK_MS))
                                   ? MSW'(MAX_TICK_MS) : MSW'(i_elapsed_ms);
                        unique case (t_kind'(i_kind))
                            KIND_LEVEL: begin
                                // samples for inactive channels are dropped silently
                                if (CCNT_W'(i_channel) < CCNT_W'(w_n)) begin
                                    r_state <= S_SAMPLE;
                                end
                            end
                            KIND_TICK: begin
                                if (r_age_valid) begin
                                    r_age <= (w_age_sum > (AGE_W + 1)'(AGE_MAX))
                                             ? AGE_W'(AGE_MAX) : w_age_sum[AGE_W-1:0];
                                end
                                r_pchg  <= '0;
                                r_upd   <= w_anim_on;
                                r_state <= w_anim_on ? S_DMUL : S_SWEEP;
                            end
                            KIND_RESET_PEAKS: begin
                                for (int i = 0; i < NCH; i++) begin
                                    r_pchg[i] <= (r_shown[i] != r_peak[i]);
                                    r_peak[i] <= r_shown[i];
                                    r_hold[i] <= r_peak_hold_ms;
                                end
                                r_state <= S_SWEEP;
                            end
                            KIND_CLEAR: begin
                                for (int i = 0; i < NCH; i++) begin
                                    r_pchg[i]   <= (r_peak[i] != r_min_level);
                                    r_target[i] <= r_min_level;
                                    r_shown[i]  <= r_min_level;
                                    r_peak[i]   <= r_min_level;
                                    r_hold[i]   <= '0;
                                end
                                r_age       <= '0;
                                r_age_valid <= 1'b0;
                                r_state     <= S_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SAMPLE: begin
                    if (w_slot) begin
                        r_target[w_ridx] <= w_bound;
                        r_shown[w_ridx]  <= w_new_shown;
                        r_peak[w_ridx]   <= w_new_peak;
                        r_hold[w_ridx]   <= w_new_hold;
                        r_age            <= '0;
                        r_age_valid      <= 1'b1;
                        r_o_valid        <= 1'b1;
                        r_o_channel      <= r_ch;
                        r_o_shown        <= w_new_shown;
                        r_o_peak         <= w_new_peak;
                        r_o_pchg         <= w_new_pchg;
                        r_o_tmo          <= 1'b0;
                        r_o_last         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                S_DMUL: begin
                    // age already holds this tick's time
                    r_tmo   <= (r_timeout_ms != '0) && r_age_valid
                               && (r_age >= AGE_W'(r_timeout_ms));
                    r_prod  <= w_prod;
                    r_state <= S_DDIV;
                end
                S_DDIV: begin
                    r_prod  <= w_prod;
                    r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_dstep <= w_quot[RATE_W-1:0];
                    r_prod  <= w_prod;
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    r_prod  <= w_prod;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (w_slot) begin
                        if (r_upd) begin
                            r_shown[w_ridx] <= w_new_shown;
                            r_peak[w_ridx]  <= w_new_peak;
                            r_hold[w_ridx]  <= w_new_hold;
                        end
                        r_o_valid   <= 1'b1;
                        r_o_channel <= CH_W'(w_ridx);
                        r_o_shown   <= w_new_shown;
                        r_o_peak    <= w_new_peak;
                        r_o_pchg    <= w_new_pchg;
                        r_o_tmo     <= r_tmo;
                        r_o_last    <= w_last;
                        if (w_last) begin
                            // timeout floors every target, active or not
                            if (r_upd && r_tmo) begin
                                for (int i = 0; i < NCH; i++) begin
                                    r_target[i] <= r_min_level;
                                end
                                r_age       <= '0;
                                r_age_valid <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_out_channel     = r_o_channel;
    assign o_displayed_level = r_o_shown;
    assign o_peak_level      = r_o_peak;
    assign o_peak_changed    = r_o_pchg;
    assign o_timed_out       = r_o_tmo;
    assign o_last            = r_o_last;

`ifndef SYNTHESIS
    // sweep never walks past the active channels
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (CCNT_W'(r_idx) < CCNT_W'(w_n)))
        else $error("sweep index beyond active channel count");

    // the final result of a sweep is flagged last and frees the input side
    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && w_slot && w_last) |=> (o_ready && o_valid && o_last))
        else $error("sweep did not end with a last result");

    // a sample produces exactly one result, for its own channel
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAMPLE && w_slot) |=>
            (o_valid && o_last && !o_timed_out && o_out_channel == $past(r_ch)))
        else $error("sample result malformed");

    // an invalid input age is always zero
    a_age_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_age_valid |-> (r_age == '0))
        else $error("input age nonzero while invalid");
`endif

endmodule
